// ----- sv/ps2hc_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2hc_pkg
// Shared types and codes for the two-port PS/2 host controller.
// ----------------------------------------------------------------------------
package ps2hc_pkg;

  // Bus action codes carried by each input item.
  localparam logic [2:0] ACT_READ_DATA   = 3'd0;
  localparam logic [2:0] ACT_READ_STATUS = 3'd1;
  localparam logic [2:0] ACT_WRITE_DATA  = 3'd2;
  localparam logic [2:0] ACT_WRITE_CMD   = 3'd3;
  localparam logic [2:0] ACT_PORT1_BYTE  = 3'd4;
  localparam logic [2:0] ACT_PORT2_BYTE  = 3'd5;

  // Controller commands.
  localparam logic [7:0] CMD_READ_CFG  = 8'h20;
  localparam logic [7:0] CMD_WRITE_CFG = 8'h60;
  localparam logic [7:0] CMD_DIS_P2    = 8'ha7;
  localparam logic [7:0] CMD_EN_P2     = 8'ha8;
  localparam logic [7:0] CMD_TEST_P2   = 8'ha9;
  localparam logic [7:0] CMD_SELF_TEST = 8'haa;
  localparam logic [7:0] CMD_TEST_P1   = 8'hab;
  localparam logic [7:0] CMD_DIS_P1    = 8'had;
  localparam logic [7:0] CMD_EN_P1     = 8'hae;
  localparam logic [7:0] CMD_SEND_P1   = 8'hd1;
  localparam logic [7:0] CMD_SEND_P2   = 8'hd4;

  // Bit positions in the controller config byte.
  localparam int CFG_BIT_IRQ1 = 0;
  localparam int CFG_BIT_IRQ2 = 1;
  localparam int CFG_BIT_SYS  = 2;
  localparam int CFG_BIT_CLK1 = 4;
  localparam int CFG_BIT_CLK2 = 5;

  localparam logic [7:0] CTRL_CFG_RESET = 8'h30;

  // Command waiting for its data byte.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_CFG  = 2'd1;
  localparam logic [1:0] PEND_P1   = 2'd2;
  localparam logic [1:0] PEND_P2   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SELF_TEST_CODE      = 2'd0;
  localparam logic [1:0] REG_PORT1_TEST_CODE     = 2'd1;
  localparam logic [1:0] REG_PORT2_TEST_CODE     = 2'd2;
  localparam logic [1:0] REG_SECOND_PORT_PRESENT = 2'd3;

  localparam logic [7:0] SELF_TEST_PASS = 8'h55;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       device_send_valid;
    logic       device_send_port;
    logic [7:0] device_send_byte;
    logic       irq_first;
    logic       irq_second;
  } out_item_t;

  typedef struct packed {
    logic [7:0] self_test_code;
    logic [2:0] port1_test_code;
    logic [2:0] port2_test_code;
    logic       second_port_present;
  } cfg_t;

endpackage

// ----- sv/ps2hc_top.sv -----
// ----------------------------------------------------------------------------
// ps2_host_controller_top
// Two-port PS/2 host controller, one bus access or device byte per item.
// ----------------------------------------------------------------------------
// Each input item is one host bus access (data read, status read, data write,
// command write) or one byte arriving from port 1 or port 2, and every item
// gives exactly one result item. The block takes one item per clock cycle;
// an item passes through an input register, a combinational decode that
// updates the controller state, and a result register, which offers its
// result on the result channel. Only a stall on the result channel slows
// the block, and then by the cycles it is held. Configuration registers
// (test codes, second port present) are written through the configuration
// channel, which is always ready.
module ps2_host_controller_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ps2hc_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ps2hc_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);
  import ps2hc_pkg::*;

  cfg_t      cfg;
  logic      stage_valid;
  in_item_t  stage_item;
  out_item_t result;
  logic      out_free;
  logic      advance;

  assign cfg_ready = 1'b1;

  ps2hc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The staged item moves on whenever the result register has room.
  assign advance  = stage_valid && out_free;
  assign in_stall = stage_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_item <= in_item;
    end
  end

  ps2hc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .cfg     (cfg),
    .result  (result)
  );

  ps2hc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (stage_valid),
    .load_item (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- sv/ps2hc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ps2hc_cfg_regs
// Configuration registers written through the configuration channel.
// ----------------------------------------------------------------------------
module ps2hc_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [1:0]       wr_index,
  input  logic [7:0]       wr_data,
  output ps2hc_pkg::cfg_t  cfg
);
  import ps2hc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_test_code      <= SELF_TEST_PASS;
      cfg.port1_test_code     <= 3'd0;
      cfg.port2_test_code     <= 3'd0;
      cfg.second_port_present <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SELF_TEST_CODE:      cfg.self_test_code      <= wr_data;
        REG_PORT1_TEST_CODE:     cfg.port1_test_code     <= wr_data[2:0];
        REG_PORT2_TEST_CODE:     cfg.port2_test_code     <= wr_data[2:0];
        REG_SECOND_PORT_PRESENT: cfg.second_port_present <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/ps2hc_core.sv -----
// ----------------------------------------------------------------------------
// ps2hc_core
// Controller state and the decode of one bus access or device byte.
// ----------------------------------------------------------------------------
module ps2hc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  ps2hc_pkg::in_item_t   item,
  input  ps2hc_pkg::cfg_t       cfg,
  output ps2hc_pkg::out_item_t  result
);
  import ps2hc_pkg::*;

  logic [7:0] controller_config, controller_config_next;
  logic [7:0] out_buffer, out_buffer_next;
  logic       out_full, out_full_next;
  logic [1:0] pending_kind, pending_kind_next;
  logic       last_was_command, last_was_command_next;

  always_comb begin
    controller_config_next = controller_config;
    out_buffer_next        = out_buffer;
    out_full_next          = out_full;
    pending_kind_next      = pending_kind;
    last_was_command_next  = last_was_command;
    result                 = '0;

    unique case (item.action)
      ACT_READ_DATA: begin
        result.read_byte = out_buffer;
        out_full_next    = 1'b0;
      end
      ACT_READ_STATUS: begin
        result.read_byte = {4'd0, last_was_command, controller_config[CFG_BIT_SYS],
                            1'b0, out_full};
      end
      ACT_WRITE_DATA: begin
        last_was_command_next = 1'b0;
        pending_kind_next     = PEND_NONE;
        if (pending_kind == PEND_CFG) begin
          controller_config_next = item.bus_byte;
        end else if (pending_kind == PEND_P2) begin
          // A byte for an absent second port is discarded.
          if (cfg.second_port_present) begin
            result.device_send_valid = 1'b1;
            result.device_send_port  = 1'b1;
            result.device_send_byte  = item.bus_byte;
          end
        end else begin
          result.device_send_valid = 1'b1;
          result.device_send_byte  = item.bus_byte;
        end
      end
      ACT_WRITE_CMD: begin
        last_was_command_next = 1'b1;
        pending_kind_next     = PEND_NONE;
        unique case (item.bus_byte)
          CMD_READ_CFG: begin
            out_buffer_next = controller_config;
            out_full_next   = 1'b1;
          end
          CMD_WRITE_CFG: pending_kind_next = PEND_CFG;
          CMD_DIS_P2:    controller_config_next[CFG_BIT_CLK2] = 1'b1;
          CMD_EN_P2: begin
            if (cfg.second_port_present) begin
              controller_config_next[CFG_BIT_CLK2] = 1'b0;
            end
          end
          CMD_TEST_P2: begin
            out_buffer_next = {5'd0, cfg.port2_test_code};
            out_full_next   = 1'b1;
          end
          CMD_SELF_TEST: begin
            out_buffer_next = cfg.self_test_code;
            out_full_next   = 1'b1;
          end
          CMD_TEST_P1: begin
            out_buffer_next = {5'd0, cfg.port1_test_code};
            out_full_next   = 1'b1;
          end
          CMD_DIS_P1:  controller_config_next[CFG_BIT_CLK1] = 1'b1;
          CMD_EN_P1:   controller_config_next[CFG_BIT_CLK1] = 1'b0;
          CMD_SEND_P1: pending_kind_next = PEND_P1;
          CMD_SEND_P2: pending_kind_next = PEND_P2;
          default: ;
        endcase
      end
      ACT_PORT1_BYTE: begin
        if (!out_full && !controller_config[CFG_BIT_CLK1]) begin
          out_buffer_next  = item.bus_byte;
          out_full_next    = 1'b1;
          result.irq_first = controller_config[CFG_BIT_IRQ1];
        end
      end
      ACT_PORT2_BYTE: begin
        if (!out_full && cfg.second_port_present && !controller_config[CFG_BIT_CLK2]) begin
          out_buffer_next   = item.bus_byte;
          out_full_next     = 1'b1;
          result.irq_second = controller_config[CFG_BIT_IRQ2];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_config <= CTRL_CFG_RESET;
      out_buffer        <= 8'd0;
      out_full          <= 1'b0;
      pending_kind      <= PEND_NONE;
      last_was_command  <= 1'b0;
    end else if (advance) begin
      controller_config <= controller_config_next;
      out_buffer        <= out_buffer_next;
      out_full          <= out_full_next;
      pending_kind      <= pending_kind_next;
      last_was_command  <= last_was_command_next;
    end
  end

endmodule

// ----- sv/ps2hc_out_reg.sv -----
// ----------------------------------------------------------------------------
// ps2hc_out_reg
// Result register that holds one item until the receiver takes it.
// ----------------------------------------------------------------------------
module ps2hc_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  ps2hc_pkg::out_item_t  load_item,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ps2hc_pkg::out_item_t  out_item
);
  import ps2hc_pkg::*;

  // The register can take a new item in the same cycle the old one leaves.
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      out_item <= load_item;
    end
  end

endmodule

// ----- bench/ps2hc_checker.sv -----
// ----------------------------------------------------------------------------
// ps2hc_checker
// Watches the channels of the PS/2 host controller and checks every result.
// ----------------------------------------------------------------------------
// Each accepted input item is decoded against a private copy of the
// controller state and the configuration registers. The result it should
// give is queued. Each accepted result item is compared field by field
// with the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ps2hc_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  ps2hc_pkg::in_item_t   in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  ps2hc_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output int                    fail_count,
  output int                    results_owed
);
  import ps2hc_pkg::*;

  // Configuration registers.
  logic [7:0] st_code;
  logic [2:0] p1_code;
  logic [2:0] p2_code;
  logic       p2_present;

  // Controller state.
  logic [7:0] ctl_cfg;
  logic [7:0] obuf;
  logic       ofull;
  logic [1:0] pend;
  logic       last_cmd;

  out_item_t access_results_q[$];
  int        mismatches = 0;

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  task automatic fill_buffer(input logic [7:0] b);
    obuf  = b;
    ofull = 1'b1;
  endtask

  task automatic send_to_device(input logic port, input logic [7:0] b,
                                inout out_item_t res);
    // A byte for the second port goes nowhere when that port is absent.
    if (!(port && !p2_present)) begin
      res.device_send_valid = 1'b1;
      res.device_send_port  = port;
      res.device_send_byte  = b;
    end
  endtask

  task automatic decode_access(input in_item_t it, output out_item_t res);
    res = '0;
    case (it.action)
      ACT_READ_DATA: begin
        res.read_byte = obuf;
        ofull = 1'b0;
      end
      ACT_READ_STATUS: begin
        res.read_byte = {4'b0000, last_cmd, ctl_cfg[CFG_BIT_SYS], 1'b0, ofull};
      end
      ACT_WRITE_DATA: begin
        last_cmd = 1'b0;
        case (pend)
          PEND_CFG: ctl_cfg = it.bus_byte;
          PEND_P2:  send_to_device(1'b1, it.bus_byte, res);
          default:  send_to_device(1'b0, it.bus_byte, res);
        endcase
        pend = PEND_NONE;
      end
      ACT_WRITE_CMD: begin
        last_cmd = 1'b1;
        pend = PEND_NONE;
        case (it.bus_byte)
          CMD_READ_CFG:  fill_buffer(ctl_cfg);
          CMD_WRITE_CFG: pend = PEND_CFG;
          CMD_DIS_P2:    ctl_cfg[CFG_BIT_CLK2] = 1'b1;
          CMD_EN_P2:     if (p2_present) ctl_cfg[CFG_BIT_CLK2] = 1'b0;
          CMD_TEST_P2:   fill_buffer({5'b00000, p2_code});
          CMD_SELF_TEST: fill_buffer(st_code);
          CMD_TEST_P1:   fill_buffer({5'b00000, p1_code});
          CMD_DIS_P1:    ctl_cfg[CFG_BIT_CLK1] = 1'b1;
          CMD_EN_P1:     ctl_cfg[CFG_BIT_CLK1] = 1'b0;
          CMD_SEND_P1:   pend = PEND_P1;
          CMD_SEND_P2:   pend = PEND_P2;
          default: ;
        endcase
      end
      ACT_PORT1_BYTE: begin
        if (!ofull && !ctl_cfg[CFG_BIT_CLK1]) begin
          fill_buffer(it.bus_byte);
          res.irq_first = ctl_cfg[CFG_BIT_IRQ1];
        end
      end
      ACT_PORT2_BYTE: begin
        if (!ofull && p2_present && !ctl_cfg[CFG_BIT_CLK2]) begin
          fill_buffer(it.bus_byte);
          res.irq_second = ctl_cfg[CFG_BIT_IRQ2];
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t res;
    if (rst) begin
      st_code    = SELF_TEST_PASS;
      p1_code    = 3'd0;
      p2_code    = 3'd0;
      p2_present = 1'b1;
      ctl_cfg    = CTRL_CFG_RESET;
      obuf       = 8'h00;
      ofull      = 1'b0;
      pend       = PEND_NONE;
      last_cmd   = 1'b0;
      access_results_q.delete();
    end else begin
      // Results are checked before the new item is queued, so a result
      // that arrives with nothing waiting is never matched to it.
      if (out_valid && !out_stall) begin
        if (access_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing waiting: %h", $realtime, out_item);
          mismatches++;
        end else begin
          want = access_results_q.pop_front();
          if (want.read_byte !== out_item.read_byte ||
              want.device_send_valid !== out_item.device_send_valid ||
              want.device_send_port !== out_item.device_send_port ||
              want.device_send_byte !== out_item.device_send_byte ||
              want.irq_first !== out_item.irq_first ||
              want.irq_second !== out_item.irq_second) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected rd %h snd %b/%b/%h irq %b%b",
                       $realtime, want.read_byte, want.device_send_valid,
                       want.device_send_port, want.device_send_byte,
                       want.irq_first, want.irq_second);
              $display("%0t:          actual   rd %h snd %b/%b/%h irq %b%b",
                       $realtime, out_item.read_byte, out_item.device_send_valid,
                       out_item.device_send_port, out_item.device_send_byte,
                       out_item.irq_first, out_item.irq_second);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_access(in_item, res);
        access_results_q.push_back(res);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SELF_TEST_CODE:      st_code    = cfg_data;
          REG_PORT1_TEST_CODE:     p1_code    = cfg_data[2:0];
          REG_PORT2_TEST_CODE:     p2_code    = cfg_data[2:0];
          REG_SECOND_PORT_PRESENT: p2_present = cfg_data[0];
          default: ;
        endcase
      end
    end
    fail_count   <= mismatches;
    results_owed <= access_results_q.size();
  end

endmodule

// ----- bench/tb_ps2_host_controller_top.sv -----
// ----------------------------------------------------------------------------
// tb_ps2_host_controller_top
// Stimulus and verdict for the two-port PS/2 host controller.
// ----------------------------------------------------------------------------
// Runs several configuration phases. The first two start with directed
// accesses covering every command and the corner cases of the output
// buffer and the ports. Then come random sequences of well-formed bus
// transactions mixed with noise. Both channels idle at random, except for
// one phase that runs back to back. Checking is done by ps2hc_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ps2_host_controller_top;
  import ps2hc_pkg::*;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         results_owed;
  logic       steady;

  ps2_host_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ps2hc_checker access_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(0, 99) < 23);
  end

  function automatic logic [7:0] pick_command(input int k);
    case (k)
      0:       pick_command = CMD_READ_CFG;
      1:       pick_command = CMD_WRITE_CFG;
      2:       pick_command = CMD_DIS_P2;
      3:       pick_command = CMD_EN_P2;
      4:       pick_command = CMD_TEST_P2;
      5:       pick_command = CMD_SELF_TEST;
      6:       pick_command = CMD_TEST_P1;
      7:       pick_command = CMD_DIS_P1;
      8:       pick_command = CMD_EN_P1;
      9:       pick_command = CMD_SEND_P1;
      default: pick_command = CMD_SEND_P2;
    endcase
  endfunction

  task automatic put_access(input logic [2:0] act, input logic [7:0] b);
    in_item_t it;
    it.action   = act;
    it.bus_byte = b;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only once every queued result has come back.
  task automatic apply_settings(input cfg_t s);
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    write_reg(REG_SELF_TEST_CODE, s.self_test_code);
    write_reg(REG_PORT1_TEST_CODE, {5'b00000, s.port1_test_code});
    write_reg(REG_PORT2_TEST_CODE, {5'b00000, s.port2_test_code});
    write_reg(REG_SECOND_PORT_PRESENT, {7'b0000000, s.second_port_present});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int         sent;
    int         pick;
    logic [7:0] b;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      b    = 8'($urandom_range(0, 255));
      if (pick < 12) begin
        // Mostly keep both port clocks running so device bytes get through.
        put_access(ACT_WRITE_CMD, CMD_WRITE_CFG);
        put_access(ACT_WRITE_DATA, ($urandom_range(0, 3) == 0) ? b : (b & 8'hcf));
        sent += 2;
      end else if (pick < 22) begin
        put_access(ACT_WRITE_CMD, $urandom_range(0, 1) ? CMD_SEND_P2 : CMD_SEND_P1);
        put_access(ACT_WRITE_DATA, b);
        sent += 2;
      end else if (pick < 40) begin
        put_access($urandom_range(0, 1) ? ACT_PORT2_BYTE : ACT_PORT1_BYTE, b);
        sent += 1;
        if ($urandom_range(0, 9) < 7) begin
          put_access(ACT_READ_STATUS, 8'($urandom_range(0, 255)));
          put_access(ACT_READ_DATA, 8'($urandom_range(0, 255)));
          sent += 2;
        end
      end else if (pick < 52) begin
        put_access(ACT_WRITE_CMD, pick_command($urandom_range(0, 10)));
        sent += 1;
      end else if (pick < 60) begin
        put_access(ACT_READ_DATA, b);
        sent += 1;
      end else if (pick < 67) begin
        put_access(ACT_READ_STATUS, b);
        sent += 1;
      end else if (pick < 75) begin
        put_access(ACT_WRITE_CMD, pick_command($urandom_range(4, 6)));
        put_access(ACT_READ_DATA, b);
        sent += 2;
      end else if (pick < 81) begin
        put_access(ACT_WRITE_CMD, $urandom_range(0, 1) ? CMD_EN_P2 : CMD_EN_P1);
        sent += 1;
      end else if (pick < 88) begin
        // A command that waits for data, cut short by another command.
        put_access(ACT_WRITE_CMD, pick_command(($urandom_range(0, 2) == 0) ? 1 : 9));
        put_access(ACT_WRITE_CMD, $urandom_range(0, 1) ? pick_command($urandom_range(0, 10)) : b);
        sent += 2;
      end else begin
        put_access(3'($urandom_range(0, 7)), b);
        sent += 1;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    steady    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_SELF_TEST_CODE;
    cfg_data  = 8'h00;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    apply_settings('{self_test_code: 8'hff, port1_test_code: 3'd4,
                     port2_test_code: 3'd3, second_port_present: 1'b1});
    put_access(ACT_READ_DATA, 8'h00);       // empty buffer gives stale zero
    put_access(ACT_PORT1_BYTE, 8'hff);      // port clock still inhibited
    put_access(ACT_WRITE_CMD, CMD_EN_P1);
    put_access(ACT_WRITE_CMD, CMD_EN_P2);
    put_access(ACT_WRITE_CMD, CMD_WRITE_CFG);
    put_access(ACT_WRITE_DATA, 8'h07);
    put_access(ACT_PORT1_BYTE, 8'ha5);
    put_access(ACT_PORT2_BYTE, 8'h5a);      // dropped, buffer full
    put_access(ACT_READ_STATUS, 8'hff);
    put_access(ACT_READ_DATA, 8'h00);
    put_access(ACT_READ_DATA, 8'hff);       // stale value again
    put_access(ACT_PORT2_BYTE, 8'h00);
    put_access(ACT_WRITE_CMD, CMD_SELF_TEST);  // overwrites the full buffer
    put_access(ACT_READ_DATA, 8'h00);
    put_access(ACT_WRITE_CMD, CMD_TEST_P1);
    put_access(ACT_WRITE_CMD, CMD_TEST_P2);
    put_access(ACT_WRITE_CMD, CMD_READ_CFG);
    put_access(ACT_READ_DATA, 8'h00);
    put_access(ACT_WRITE_CMD, CMD_SEND_P1);
    put_access(ACT_WRITE_DATA, 8'h80);
    put_access(ACT_WRITE_CMD, CMD_SEND_P2);
    put_access(ACT_WRITE_DATA, 8'h7f);
    put_access(ACT_WRITE_DATA, 8'h11);      // nothing pending goes to port 1
    put_access(ACT_WRITE_CMD, CMD_WRITE_CFG);
    put_access(ACT_WRITE_CMD, CMD_DIS_P1);  // drops the pending config write
    put_access(ACT_WRITE_CMD, 8'hff);
    put_access(3'd6, 8'h00);
    put_access(3'd7, 8'hff);
    run_random(200);

    apply_settings('{self_test_code: 8'h00, port1_test_code: 3'd0,
                     port2_test_code: 3'd0, second_port_present: 1'b0});
    put_access(ACT_WRITE_CMD, CMD_DIS_P2);
    put_access(ACT_WRITE_CMD, CMD_EN_P2);   // ignored without a second port
    put_access(ACT_WRITE_CMD, CMD_READ_CFG);
    put_access(ACT_READ_DATA, 8'h00);
    put_access(ACT_WRITE_CMD, CMD_SEND_P2);
    put_access(ACT_WRITE_DATA, 8'h3c);      // discarded
    put_access(ACT_PORT2_BYTE, 8'hc3);
    run_random(250);

    apply_settings('{self_test_code: 8'h55, port1_test_code: 3'd0,
                     port2_test_code: 3'd4, second_port_present: 1'b1});
    steady <= 1'b1;
    run_random(250);
    @(negedge clk);
    steady <= 1'b0;

    apply_settings('{self_test_code: 8'($urandom_range(0, 255)),
                     port1_test_code: 3'($urandom_range(0, 4)),
                     port2_test_code: 3'($urandom_range(0, 4)),
                     second_port_present: 1'($urandom_range(0, 1))});
    run_random(250);

    apply_settings('{self_test_code: 8'hfc, port1_test_code: 3'd4,
                     port2_test_code: 3'd4, second_port_present: 1'b1});
    run_random(270);

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/ps2hc_pkg.sv
sv/ps2hc_cfg_regs.sv
sv/ps2hc_core.sv
sv/ps2hc_out_reg.sv
sv/ps2hc_top.sv
bench/ps2hc_checker.sv
bench/tb_ps2_host_controller_top.sv
